// ===== rtl/rfft_pkg.sv =====
// Package for the radix-4 FFT frame engine: sizes, types, twiddle and reorder functions.
package rfft_pkg;

  localparam int POINTS_LOG2 = 10;
  localparam int NPTS        = 1 << POINTS_LOG2;
  localparam int HALFN       = NPTS >> 1;
  localparam int QUARTN      = NPTS >> 2;
  localparam int SAMPLE_W    = 18;
  localparam int DATA_W      = 32;
  localparam int TW_W        = 19;
  localparam int BF_W        = POINTS_LOG2 - 1;
  localparam int QL_W        = $clog2(POINTS_LOG2 + 1);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int TW_MAX      = 131071;
  localparam real TWO_PI     = 6.283185307179586476925;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_ON_LOAD  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_ON_STORE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE  = CFG_IDX_W'(3);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [TW_W-1:0] wr;
    logic signed [TW_W-1:0] wi;
  } tw_t;

  typedef struct packed {
    logic inv;
    logic r2;
  } bf_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_RD,
    ST_WAIT,
    ST_WR
  } st_e;

  typedef logic [16:0] sine_tab_t [QUARTN+1];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    real x;
    int v;
    for (int k = 0; k <= QUARTN; k++) begin
      x = $sin(TWO_PI * k / NPTS) * 131072.0;
      v = $rtoi(x + 0.5);
      if (v > TW_MAX) v = TW_MAX;
      if (v < 0) v = 0;
      tab[k] = 17'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  localparam tw_t TW_UNITY = '{wr: TW_W'(131072), wi: '0};

  // Quarter-wave fold of e^(-j2*pi*t/N); the sine term flips in inverse mode.
  function automatic tw_t twiddle(logic [POINTS_LOG2-1:0] t, logic inv);
    tw_t w;
    logic neg;
    logic [POINTS_LOG2-2:0] r;
    logic [POINTS_LOG2-2:0] qn;
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    neg = t[POINTS_LOG2-1];
    r   = t[POINTS_LOG2-2:0];
    qn  = (POINTS_LOG2-1)'(QUARTN);
    if (r <= qn) begin
      c = TW_W'(SINE_TAB[qn - r]);
      s = TW_W'(SINE_TAB[r]);
    end else begin
      c = -TW_W'(SINE_TAB[r - qn]);
      s = TW_W'(SINE_TAB[~r + 1'b1]);
    end
    if (neg) begin
      c = -c;
      s = -s;
    end
    w.wr = c;
    w.wi = inv ? s : -s;
    return w;
  endfunction

  // Base-4 digit reversal, with the top bit moved to bit 0 for odd sizes.
  function automatic logic [POINTS_LOG2-1:0] input_order(logic [POINTS_LOG2-1:0] n);
    logic [POINTS_LOG2-1:0] r;
    logic [POINTS_LOG2-1:0] x;
    r = '0;
    x = n;
    for (int d = 0; d < POINTS_LOG2 / 2; d++) begin
      r = (r << 2) | POINTS_LOG2'(x[1:0]);
      x = x >> 2;
    end
    if (POINTS_LOG2 % 2 == 1) r = (r << 1) | POINTS_LOG2'(x[0]);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/rfft_in_if.sv =====
// Input channel of the FFT frame engine: push or pop requests with sample payload.
interface rfft_in_if;
  import rfft_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;
  logic signed [SAMPLE_W-1:0] window_coeff;
  modport source (output valid, op, sample_re, sample_im, window_coeff, input ready);
  modport sink (input valid, op, sample_re, sample_im, window_coeff, output ready);
endinterface

// ===== rtl/rfft_out_if.sv =====
// Output channel of the FFT frame engine: popped result samples.
interface rfft_out_if;
  import rfft_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_re;
  logic signed [DATA_W-1:0] out_im;
  logic                     last;
  logic                     empty_res;
  modport source (output valid, out_re, out_im, last, empty_res, input ready);
  modport sink (input valid, out_re, out_im, last, empty_res, output ready);
endinterface

// ===== rtl/rfft_cfg_if.sv =====
// Configuration write channel of the FFT frame engine.
interface rfft_cfg_if;
  import rfft_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rfft_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module rfft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/rfft_bfly.sv =====
// Four-point (or two-point) butterfly sums on twiddled operands, saturated to 32 bits.
module rfft_bfly (
  input  rfft_pkg::cplx_t    ops_i [4],
  input  rfft_pkg::bf_ctrl_t ctrl_i,
  output rfft_pkg::cplx_t    y_o [4]
);
  import rfft_pkg::*;

  logic signed [35:0] ar, ai, br, bi, cr, ci, dr, di;
  cplx_t p, m;

  always_comb begin
    ar = 36'(ops_i[0].re);
    ai = 36'(ops_i[0].im);
    br = 36'(ops_i[1].re);
    bi = 36'(ops_i[1].im);
    cr = 36'(ops_i[2].re);
    ci = 36'(ops_i[2].im);
    dr = 36'(ops_i[3].re);
    di = 36'(ops_i[3].im);
    p.re = sat32(ar + bi - cr - di);
    p.im = sat32(ai - br - ci + dr);
    m.re = sat32(ar - bi - cr + di);
    m.im = sat32(ai + br - ci - dr);
    if (ctrl_i.r2) begin
      y_o[0].re = sat32(ar + br);
      y_o[0].im = sat32(ai + bi);
      y_o[1].re = sat32(ar - br);
      y_o[1].im = sat32(ai - bi);
      y_o[2]    = p;
      y_o[3]    = m;
    end else begin
      y_o[0].re = sat32(ar + br + cr + dr);
      y_o[0].im = sat32(ai + bi + ci + di);
      y_o[2].re = sat32(ar - br + cr - dr);
      y_o[2].im = sat32(ai - bi + ci - di);
      y_o[1]    = ctrl_i.inv ? m : p;
      y_o[3]    = ctrl_i.inv ? p : m;
    end
  end
endmodule

// ===== rtl/radix4_fft_frame_engine.sv =====
// Top level of the radix-4 FFT frame engine: load, transform sequencer and result drain.
//
// The engine collects N = 2^POINTS_LOG2 pushed samples into a sample memory, optionally
// windowed and half-swapped, and transforms the frame when the N-th sample arrives. The
// transform first copies the frame into a working memory in base-4 digit-reversed order,
// then runs every butterfly of every stage through one shared unit that reads its
// operands, twiddles them with one complex multiplier and writes the results back in
// place: a radix-4 butterfly reads four operands, passes them through the multiplier
// pipeline and writes four results, and a two-point butterfly reads and writes two. The
// input channel holds ready low while the transform runs. Pushes may otherwise follow
// back to back. A pop's result is read from the working memory and passes through the
// registered memory read into the output register. The input takes nothing in the cycle
// right after a pop, so pops cannot come back to back, and a pop is not taken while the
// output register holds a result nobody has taken. Pushes that arrive while a finished
// frame waits to be drained are taken and dropped. Pops with no finished frame return an
// empty result. Inverse mode is captured when a frame completes, and its 1/N scaling is
// applied as results are read out.
module radix4_fft_frame_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfft_in_if.sink     in_i,
  rfft_out_if.source  out_o,
  rfft_cfg_if.sink    cfg_i
);
  import rfft_pkg::*;

  localparam int P = POINTS_LOG2;

  // Configuration registers.
  logic cfg_inv_q, cfg_sol_q, cfg_sos_q, cfg_win_q;

  // Frame bookkeeping.
  logic [P-1:0] fill_q, fill_d;
  logic [P-1:0] drain_q, drain_d;
  logic         frame_ready_q, frame_ready_d;
  logic         frame_inv_q, frame_inv_d;

  // Transform sequencer.
  st_e          state_q, state_d;
  logic [P:0]   cnt_q, cnt_d;
  logic [1:0]   m_q, m_d;
  logic [BF_W-1:0] bf_q, bf_d;
  logic [QL_W-1:0] ql_q, ql_d;
  logic         r2_q, r2_d;

  // Copy and butterfly pipelines.
  logic         cpy_v_q;
  logic [P-1:0] cpy_a_q;
  logic         v1_q, v2_q;
  logic [1:0]   tag1_q, tag2_q;
  tw_t          w1_q;
  logic signed [DATA_W+TW_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  cplx_t        ops_q [4];
  cplx_t        y_q [4];
  cplx_t        y_c [4];

  // Output side.
  logic         pend_q, pend_last_q, pend_empty_q;
  logic         out_valid_q, out_last_q, out_empty_q;
  logic signed [DATA_W-1:0] out_re_q, out_im_q;

  // Memories.
  logic         a_we, b_we;
  logic [P-1:0] a_waddr, b_waddr, b_raddr;
  cplx_t        a_wdata, b_wdata, a_rdata, b_rdata;

  // Handshakes.
  logic in_xfer, push_xfer, pop_xfer, push_eff, push_done;
  logic cfg_xfer;

  // Butterfly addressing.
  logic [1:0]   m_last;
  logic         bf_last, stage_last;
  logic [P-1:0] bfx, k_idx, i0, addr_m, t1, t_m;
  logic [P-1:0] pop_addr;
  logic signed [DATA_W-1:0] load_re, load_im;
  logic signed [2*SAMPLE_W-1:0] win_re, win_im;
  logic signed [DATA_W+TW_W:0] mul_re, mul_im;
  logic signed [DATA_W:0] sc_re, sc_im;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;

  // A pop needs the output register free by the time its read data returns.
  assign in_i.ready = (state_q == ST_IDLE) && !pend_q &&
                      ((in_i.op == OP_PUSH) || !out_valid_q || out_o.ready);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign push_xfer  = in_xfer && (in_i.op == OP_PUSH);
  assign pop_xfer   = in_xfer && (in_i.op == OP_POP);
  assign push_eff   = push_xfer && !frame_ready_q;
  assign push_done  = push_eff && (fill_q == P'(NPTS - 1));

  // Load path: optional window multiply with rounding, written straight to the sample memory.
  always_comb begin
    win_re = in_i.sample_re * in_i.window_coeff + (2*SAMPLE_W)'(65536);
    win_im = in_i.sample_im * in_i.window_coeff + (2*SAMPLE_W)'(65536);
    if (cfg_win_q) begin
      load_re = DATA_W'(win_re >>> 17);
      load_im = DATA_W'(win_im >>> 17);
    end else begin
      load_re = DATA_W'(in_i.sample_re);
      load_im = DATA_W'(in_i.sample_im);
    end
  end

  assign a_we       = push_eff;
  assign a_waddr    = fill_q ^ {cfg_sol_q, {(P-1){1'b0}}};
  assign a_wdata.re = load_re;
  assign a_wdata.im = load_im;

  rfft_ram #(.WIDTH(2*DATA_W), .DEPTH(NPTS)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (cnt_q[P-1:0]),
    .rdata_o (a_rdata)
  );

  // Butterfly element addresses and twiddle exponents for the current stage.
  always_comb begin
    m_last     = r2_q ? 2'd1 : 2'd3;
    bf_last    = r2_q ? (bf_q == BF_W'(HALFN - 1)) : (bf_q == BF_W'(QUARTN - 1));
    stage_last = !r2_q && (int'(ql_q) + 4 > P);
    bfx        = P'(bf_q);
    k_idx      = bfx & ((P'(1) << ql_q) - P'(1));
    i0         = ((bfx >> ql_q) << (ql_q + QL_W'(2))) | k_idx;
    if (r2_q) addr_m = {bf_q[P-2:0], m_q[0]};
    else addr_m = i0 + (P'(m_q) << ql_q);
    t1 = k_idx << (QL_W'(P - 2) - ql_q);
    case (m_q)
      2'd1:    t_m = t1;
      2'd2:    t_m = t1 << 1;
      2'd3:    t_m = (t1 << 1) + t1;
      default: t_m = '0;
    endcase
  end

  assign pop_addr = drain_q ^ {cfg_sos_q, {(P-1){1'b0}}};

  // The working memory is written by the reorder copy or the butterfly write-back, never both.
  assign b_we    = cpy_v_q || (state_q == ST_WR);
  assign b_waddr = cpy_v_q ? input_order(cpy_a_q) : addr_m;
  assign b_wdata = cpy_v_q ? a_rdata : y_q[m_q];
  assign b_raddr = (state_q == ST_RD) ? addr_m : pop_addr;

  rfft_ram #(.WIDTH(2*DATA_W), .DEPTH(NPTS)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  rfft_bfly u_bfly (
    .ops_i  (ops_q),
    .ctrl_i ('{inv: frame_inv_q, r2: r2_q}),
    .y_o    (y_c)
  );

  // Rounding and saturation after the registered products.
  always_comb begin
    mul_re = (DATA_W+TW_W+1)'(p_rr_q) - (DATA_W+TW_W+1)'(p_ii_q) + (DATA_W+TW_W+1)'(65536);
    mul_im = (DATA_W+TW_W+1)'(p_ri_q) + (DATA_W+TW_W+1)'(p_ir_q) + (DATA_W+TW_W+1)'(65536);
  end

  // Readout scaling by 1/N for inverse frames.
  always_comb begin
    sc_re = ((DATA_W+1)'(b_rdata.re) + (DATA_W+1)'(1 << (P - 1))) >>> P;
    sc_im = ((DATA_W+1)'(b_rdata.im) + (DATA_W+1)'(1 << (P - 1))) >>> P;
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (push_done) state_d = ST_COPY;
      ST_COPY: if (cnt_q[P]) state_d = ST_RD;
      ST_RD:   if (m_q == m_last) state_d = ST_WAIT;
      ST_WAIT: if (!v1_q && !v2_q) state_d = ST_WR;
      ST_WR: begin
        if (m_q == m_last) state_d = (bf_last && stage_last) ? ST_IDLE : ST_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer counters and frame bookkeeping.
  always_comb begin
    cnt_d         = cnt_q;
    m_d           = m_q;
    bf_d          = bf_q;
    ql_d          = ql_q;
    r2_d          = r2_q;
    fill_d        = fill_q;
    drain_d       = drain_q;
    frame_ready_d = frame_ready_q;
    frame_inv_d   = frame_inv_q;
    case (state_q)
      ST_IDLE: begin
        if (push_eff) fill_d = fill_q + P'(1);
        if (push_done) begin
          fill_d      = '0;
          drain_d     = '0;
          frame_inv_d = cfg_inv_q;
          cnt_d       = '0;
          m_d         = '0;
          bf_d        = '0;
          r2_d        = (P % 2 == 1);
          ql_d        = (P % 2 == 1) ? QL_W'(1) : QL_W'(0);
        end
        if (pop_xfer && frame_ready_q) begin
          drain_d = drain_q + P'(1);
          if (drain_q == P'(NPTS - 1)) frame_ready_d = 1'b0;
        end
      end
      ST_COPY: if (!cnt_q[P]) cnt_d = cnt_q + (P+1)'(1);
      ST_RD:   m_d = (m_q == m_last) ? 2'd0 : m_q + 2'd1;
      ST_WR: begin
        m_d = (m_q == m_last) ? 2'd0 : m_q + 2'd1;
        if (m_q == m_last) begin
          if (bf_last) begin
            bf_d = '0;
            if (r2_q) r2_d = 1'b0;
            else ql_d = ql_q + QL_W'(2);
            if (stage_last) frame_ready_d = 1'b1;
          end else begin
            bf_d = bf_q + BF_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_inv_q     <= 1'b0;
      cfg_sol_q     <= 1'b0;
      cfg_sos_q     <= 1'b1;
      cfg_win_q     <= 1'b0;
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      m_q           <= '0;
      bf_q          <= '0;
      ql_q          <= '0;
      r2_q          <= 1'b0;
      fill_q        <= '0;
      drain_q       <= '0;
      frame_ready_q <= 1'b0;
      frame_inv_q   <= 1'b0;
      cpy_v_q       <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        case (cfg_i.index)
          CFG_INVERSE_MODE:   cfg_inv_q <= cfg_i.data[0];
          CFG_SHIFT_ON_LOAD:  cfg_sol_q <= cfg_i.data[0];
          CFG_SHIFT_ON_STORE: cfg_sos_q <= cfg_i.data[0];
          CFG_WINDOW_ENABLE:  cfg_win_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      m_q           <= m_d;
      bf_q          <= bf_d;
      ql_q          <= ql_d;
      r2_q          <= r2_d;
      fill_q        <= fill_d;
      drain_q       <= drain_d;
      frame_ready_q <= frame_ready_d;
      frame_inv_q   <= frame_inv_d;
      cpy_v_q       <= (state_q == ST_COPY) && !cnt_q[P];
      v1_q          <= (state_q == ST_RD);
      v2_q          <= v1_q;
      pend_q        <= pop_xfer;
      if (pend_q) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cpy_a_q <= cnt_q[P-1:0];
    tag1_q  <= m_q;
    w1_q    <= (m_q == 2'd0 || r2_q) ? TW_UNITY : twiddle(t_m, frame_inv_q);
    tag2_q  <= tag1_q;
    p_rr_q  <= b_rdata.re * w1_q.wr;
    p_ii_q  <= b_rdata.im * w1_q.wi;
    p_ri_q  <= b_rdata.re * w1_q.wi;
    p_ir_q  <= b_rdata.im * w1_q.wr;
    if (v2_q) begin
      ops_q[tag2_q].re <= sat32(36'(mul_re >>> 17));
      ops_q[tag2_q].im <= sat32(36'(mul_im >>> 17));
    end
    if (state_q == ST_WAIT && !v1_q && !v2_q) y_q <= y_c;
    if (pop_xfer) begin
      pend_last_q  <= frame_ready_q && (drain_q == P'(NPTS - 1));
      pend_empty_q <= !frame_ready_q;
    end
    if (pend_q) begin
      out_last_q  <= pend_last_q;
      out_empty_q <= pend_empty_q;
      if (pend_empty_q) begin
        out_re_q <= '0;
        out_im_q <= '0;
      end else if (frame_inv_q) begin
        out_re_q <= sc_re[DATA_W-1:0];
        out_im_q <= sc_im[DATA_W-1:0];
      end else begin
        out_re_q <= b_rdata.re;
        out_im_q <= b_rdata.im;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_re    = out_re_q;
  assign out_o.out_im    = out_im_q;
  assign out_o.last      = out_last_q;
  assign out_o.empty_res = out_empty_q;

`ifndef NO_ASSERTIONS
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input taken while the transform runs");

  a_pop_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> out_valid_q)
    else $error("pop result did not reach the output register");

  a_last_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_xfer && frame_ready_q && (drain_q == P'(NPTS - 1))) |=> !frame_ready_q)
    else $error("frame still ready after its last result");

  a_run_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (fill_q == '0) && !frame_ready_q)
    else $error("fill count or ready flag set during the transform");
`endif

endmodule

// ===== sim/radix4_fft_frame_engine_tb.sv =====
// Self-checking testbench for the radix-4 FFT frame engine: random frames checked against a predictor.
module radix4_fft_frame_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfft_pkg::*;

  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic signed [SAMPLE_W-1:0] coeff;
  } fft_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
    logic                     empty_res;
  } fft_res_t;

  logic clk_i;
  logic rst_ni;

  rfft_in_if  in_ch ();
  rfft_out_if out_ch ();
  rfft_cfg_if cfg_ch ();

  radix4_fft_frame_engine dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // The clock runs freely with a 20 ns period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Stimulus and expectation queues, plus the knobs the phases turn.
  fft_req_t pending_reqs[$];
  fft_res_t expected_pops[$];
  int       queued_total;
  int       accepted_total;
  int       idle_mode;
  bit       failed;
  int       quiet_cycles;

  // Predictor state: the frame memory, its counters and the register copies.
  int signed store_re[NPTS];
  int signed store_im[NPTS];
  int signed work_re[NPTS];
  int signed work_im[NPTS];
  int signed quarter_sine[QUARTN+1];
  int        fill_cnt;
  int        drain_cnt;
  bit        frame_full;
  bit        inv_reg;
  bit        load_swap_reg;
  bit        store_swap_reg;
  bit        window_reg;

  function automatic int signed clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint round_down(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Twiddle e^(-j2*pi*t/N) from the folded quarter-wave sine table.
  function automatic void twiddle_of(int t, bit inv, output int signed wr,
                                     output int signed wi);
    int  r;
    int signed c;
    int signed s;
    bit  neg;
    t   = t % NPTS;
    neg = (t >= HALFN);
    r   = neg ? t - HALFN : t;
    if (r <= QUARTN) begin
      c = quarter_sine[QUARTN - r];
      s = quarter_sine[r];
    end else begin
      c = -quarter_sine[r - QUARTN];
      s = quarter_sine[HALFN - r];
    end
    if (neg) begin
      c = -c;
      s = -s;
    end
    wr = c;
    wi = inv ? s : -s;
  endfunction

  function automatic void rotate(inout int signed xr, inout int signed xi, input int t,
                                 input bit inv);
    int signed wr;
    int signed wi;
    longint    pr;
    longint    pi;
    twiddle_of(t, inv, wr, wi);
    pr = longint'(xr) * wr - longint'(xi) * wi;
    pi = longint'(xr) * wi + longint'(xi) * wr;
    xr = clip32(round_down(pr, 17));
    xi = clip32(round_down(pi, 17));
  endfunction

  function automatic int digit_reverse(int n);
    int r;
    int x;
    r = 0;
    x = n;
    for (int d = 0; d < POINTS_LOG2 / 2; d++) begin
      r = (r << 2) | (x & 3);
      x = x >> 2;
    end
    if (POINTS_LOG2 % 2 == 1) r = (r << 1) | (x & 1);
    return r % NPTS;
  endfunction

  // Whole-frame transform, run the moment the last sample of a frame is taken.
  function automatic void transform_frame();
    int        q;
    int        step;
    int        k;
    int        i0;
    int        i1;
    int        i2;
    int        i3;
    longint    ar, ai, br, bi, cr, ci, dr, di;
    int signed b_re, b_im, c_re, c_im, d_re, d_im;
    int signed pr, pi, mr, mi;
    longint    sa, sb;
    q = 1;
    for (int i = 0; i < NPTS; i++) begin
      work_re[digit_reverse(i)] = store_re[i];
      work_im[digit_reverse(i)] = store_im[i];
    end
    if (POINTS_LOG2 % 2 == 1) begin
      for (int i = 0; i < HALFN; i++) begin
        sa = work_re[2*i];
        sb = work_re[2*i+1];
        work_re[2*i]   = clip32(sa + sb);
        work_re[2*i+1] = clip32(sa - sb);
        sa = work_im[2*i];
        sb = work_im[2*i+1];
        work_im[2*i]   = clip32(sa + sb);
        work_im[2*i+1] = clip32(sa - sb);
      end
      q = 2;
    end
    while (q * 4 <= NPTS) begin
      step = NPTS / (q * 4);
      for (int bf = 0; bf < QUARTN; bf++) begin
        k  = bf % q;
        i0 = (bf / q) * (q * 4) + k;
        i1 = i0 + q;
        i2 = i1 + q;
        i3 = i2 + q;
        b_re = work_re[i1];
        b_im = work_im[i1];
        c_re = work_re[i2];
        c_im = work_im[i2];
        d_re = work_re[i3];
        d_im = work_im[i3];
        rotate(b_re, b_im, k * step, inv_reg);
        rotate(c_re, c_im, 2 * k * step, inv_reg);
        rotate(d_re, d_im, 3 * k * step, inv_reg);
        ar = work_re[i0];
        ai = work_im[i0];
        br = b_re; bi = b_im; cr = c_re; ci = c_im; dr = d_re; di = d_im;
        work_re[i0] = clip32(ar + br + cr + dr);
        work_im[i0] = clip32(ai + bi + ci + di);
        work_re[i2] = clip32(ar - br + cr - dr);
        work_im[i2] = clip32(ai - bi + ci - di);
        pr = clip32(ar + bi - cr - di);
        pi = clip32(ai - br - ci + dr);
        mr = clip32(ar - bi - cr + di);
        mi = clip32(ai + br - ci - dr);
        // Inverse mode swaps the two odd outputs.
        work_re[i1] = inv_reg ? mr : pr;
        work_im[i1] = inv_reg ? mi : pi;
        work_re[i3] = inv_reg ? pr : mr;
        work_im[i3] = inv_reg ? pi : mi;
      end
      q = q * 4;
    end
    for (int i = 0; i < NPTS; i++) begin
      store_re[i] = inv_reg ? clip32(round_down(work_re[i], POINTS_LOG2)) : work_re[i];
      store_im[i] = inv_reg ? clip32(round_down(work_im[i], POINTS_LOG2)) : work_im[i];
    end
  endfunction

  // Advances the predictor by one accepted request.
  function automatic void predict_request(fft_req_t req);
    longint   re;
    longint   im;
    int       pos;
    int       src;
    fft_res_t res;
    if (req.op == OP_PUSH) begin
      // A push is dropped while a finished frame is still waiting to drain.
      if (frame_full) return;
      re = req.re;
      im = req.im;
      if (window_reg) begin
        re = round_down(re * req.coeff, 17);
        im = round_down(im * req.coeff, 17);
      end
      pos = fill_cnt ^ (load_swap_reg ? HALFN : 0);
      store_re[pos] = clip32(re);
      store_im[pos] = clip32(im);
      fill_cnt++;
      if (fill_cnt >= NPTS) begin
        transform_frame();
        fill_cnt   = 0;
        drain_cnt  = 0;
        frame_full = 1'b1;
      end
      return;
    end
    if (!frame_full) begin
      // A pop with nothing finished returns an empty, zeroed result.
      res = '{re: '0, im: '0, last: 1'b0, empty_res: 1'b1};
    end else begin
      src = drain_cnt ^ (store_swap_reg ? HALFN : 0);
      res = '{re: store_re[src], im: store_im[src], last: (drain_cnt == NPTS - 1),
              empty_res: 1'b0};
      drain_cnt++;
      if (drain_cnt >= NPTS) begin
        drain_cnt  = 0;
        frame_full = 1'b0;
      end
    end
    expected_pops.push_back(res);
  endfunction

  // Sender: keeps valid up until the transfer, and may pause between items.
  always @(posedge clk_i or negedge rst_ni) begin
    fft_req_t req;
    int       gap_pct;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      gap_pct = (idle_mode == 1) ? 50 : (idle_mode == 3) ? 26 : 0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
        req = pending_reqs.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.op           <= req.op;
        in_ch.sample_re    <= req.re;
        in_ch.sample_im    <= req.im;
        in_ch.window_coeff <= req.coeff;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random in the phases that ask for it.
  always @(posedge clk_i or negedge rst_ni) begin
    int stall_pct;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_pct = (idle_mode == 2) ? 50 : (idle_mode == 3) ? 26 : 0;
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predictor update on every transfer of the input and configuration channels.
  always @(posedge clk_i) begin
    fft_req_t req;
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_INVERSE_MODE:   inv_reg        = cfg_ch.data[0];
        CFG_SHIFT_ON_LOAD:  load_swap_reg  = cfg_ch.data[0];
        CFG_SHIFT_ON_STORE: store_swap_reg = cfg_ch.data[0];
        CFG_WINDOW_ENABLE:  window_reg     = cfg_ch.data[0];
        default: ;
      endcase
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      req = '{op: in_ch.op, re: in_ch.sample_re, im: in_ch.sample_im,
              coeff: in_ch.window_coeff};
      predict_request(req);
      accepted_total++;
    end
  end

  // Result checker and stall watchdog.
  always @(posedge clk_i) begin
    fft_res_t exp_res;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pops.size() == 0) begin
          $display("%0t: unexpected result re=%0d im=%0d last=%0b empty=%0b", $time,
                   out_ch.out_re, out_ch.out_im, out_ch.last, out_ch.empty_res);
          failed = 1'b1;
        end else begin
          exp_res = expected_pops.pop_front();
          if (out_ch.out_re !== exp_res.re) begin
            $display("%0t: out_re expected %0d actual %0d", $time, exp_res.re,
                     out_ch.out_re);
            failed = 1'b1;
          end
          if (out_ch.out_im !== exp_res.im) begin
            $display("%0t: out_im expected %0d actual %0d", $time, exp_res.im,
                     out_ch.out_im);
            failed = 1'b1;
          end
          if (out_ch.last !== exp_res.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_res.last,
                     out_ch.last);
            failed = 1'b1;
          end
          if (out_ch.empty_res !== exp_res.empty_res) begin
            $display("%0t: empty_res expected %0b actual %0b", $time,
                     exp_res.empty_res, out_ch.empty_res);
            failed = 1'b1;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic add_request(logic op, logic signed [SAMPLE_W-1:0] re,
                             logic signed [SAMPLE_W-1:0] im,
                             logic signed [SAMPLE_W-1:0] coeff);
    pending_reqs.push_back('{op: op, re: re, im: im, coeff: coeff});
    queued_total++;
  endtask

  // Random pushes; now and then a pop slips in, which must come back empty.
  task automatic add_pushes(int count, int mag_bits);
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(15) == 0) add_request(OP_POP, 0, 0, 0);
      re = SAMPLE_W'($urandom());
      im = SAMPLE_W'($urandom());
      if (mag_bits < SAMPLE_W) begin
        re = re >>> (SAMPLE_W - mag_bits);
        im = im >>> (SAMPLE_W - mag_bits);
      end
      add_request(OP_PUSH, re, im, SAMPLE_W'($urandom()));
    end
  endtask

  // Pops; stray pushes in between fall on a full frame and are dropped.
  task automatic add_pops(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(15) == 0) begin
        add_request(OP_PUSH, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
                    SAMPLE_W'($urandom()));
      end
      add_request(OP_POP, 0, 0, 0);
    end
  endtask

  // Waits until every queued item is taken and every result is back.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (accepted_total != queued_total || expected_pops.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    real x;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_PUSH;
    in_ch.sample_re    = '0;
    in_ch.sample_im    = '0;
    in_ch.window_coeff = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    idle_mode          = 0;
    failed             = 1'b0;
    quiet_cycles       = 0;
    queued_total       = 0;
    accepted_total     = 0;
    fill_cnt           = 0;
    drain_cnt          = 0;
    frame_full         = 1'b0;
    inv_reg            = 1'b0;
    load_swap_reg      = 1'b0;
    store_swap_reg     = 1'b1;
    window_reg         = 1'b0;
    for (int k = 0; k <= QUARTN; k++) begin
      x = $sin(6.283185307179586 * k / NPTS) * 131072.0;
      quarter_sine[k] = $rtoi(x + 0.5);
      if (quarter_sine[k] > TW_MAX) quarter_sine[k] = TW_MAX;
      if (quarter_sine[k] < 0) quarter_sine[k] = 0;
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First half of the frame: windowing on, extreme samples, no idling. An
    // unknown index is ignored and only bit 0 of the data counts.
    write_reg(CFG_IDX_W'(7), 32'h1);
    write_reg(CFG_WINDOW_ENABLE, 32'hffff_ffff);
    idle_mode = 0;
    add_request(OP_POP, 0, 0, 0);
    add_request(OP_POP, 0, 0, 0);
    add_request(OP_PUSH, 18'sh1ffff, -18'sh20000, 18'sh1ffff);
    add_request(OP_PUSH, -18'sh20000, 18'sh1ffff, -18'sh20000);
    add_request(OP_PUSH, -18'sh20000, -18'sh20000, -18'sh20000);
    add_request(OP_PUSH, 18'sh1ffff, 18'sh1ffff, -1);
    add_request(OP_PUSH, 0, 0, 0);
    add_request(OP_PUSH, -1, 1, 1);
    add_pushes(HALFN - 6, SAMPLE_W);
    wait_drained();

    // Second half: load swap on, windowing off, and inverse mode set before
    // the frame completes, so the frame is transformed as an inverse one.
    write_reg(CFG_SHIFT_ON_LOAD, 32'h1);
    write_reg(CFG_WINDOW_ENABLE, 32'h2);
    write_reg(CFG_INVERSE_MODE, 32'h3);
    idle_mode = 1;
    add_pushes(HALFN, SAMPLE_W);
    wait_drained();

    // Drain part of the frame with the store swap flipped halfway through.
    idle_mode = 2;
    add_pops(360);
    wait_drained();
    write_reg(CFG_SHIFT_ON_STORE, 32'h0);
    idle_mode = 3;
    add_pops(360);
    wait_drained();

    repeat (30) @(posedge clk_i);
    if (!failed && expected_pops.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rfft_pkg.sv
rtl/rfft_in_if.sv
rtl/rfft_out_if.sv
rtl/rfft_cfg_if.sv
rtl/rfft_ram.sv
rtl/rfft_bfly.sv
rtl/radix4_fft_frame_engine.sv
sim/radix4_fft_frame_engine_tb.sv
